FILE: rtl/fsk_pkg.sv
// ----------------------------------------------------------------------------
// fsk_pkg
// Shared widths, register indexes, controller/datapath interface types and the
// saturating-increment helper of the run-pair FSK demodulator.
// ----------------------------------------------------------------------------
`default_nettype none

package fsk_pkg;

  localparam int CNT_W    = 16;
  localparam int PER_W    = CNT_W + 1;
  localparam int CFG_W    = 16;
  localparam int PPB_W    = 6;
  localparam int IDX_W    = 3;
  localparam int BCNT_W   = 16;
  localparam int DIV_W    = CNT_W + 1;
  localparam int STEP_W   = $clog2(DIV_W + 1);
  localparam int CMP_W    = (PER_W > CFG_W) ? PER_W : CFG_W;
  localparam int QEXT_W   = DIV_W + BCNT_W;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [BCNT_W-1:0] BCNT_MAX = {BCNT_W{1'b1}};

  localparam logic [CFG_W-1:0] MIN_PERIOD_RST   = CFG_W'(6);
  localparam logic [CFG_W-1:0] MAX_PERIOD_RST   = CFG_W'(13);
  localparam logic [CFG_W-1:0] SPLIT_PERIOD_RST = CFG_W'(9);
  localparam logic [PPB_W-1:0] PPZ_RST          = PPB_W'(6);
  localparam logic [PPB_W-1:0] PPO_RST          = PPB_W'(5);

  typedef enum logic [IDX_W-1:0] {
    REG_MIN_PERIOD   = 3'd0,
    REG_MAX_PERIOD   = 3'd1,
    REG_SPLIT_PERIOD = 3'd2,
    REG_PPZ          = 3'd3,
    REG_PPO          = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic run;
    logic classify;
    logic push;
  } fsk_cmd_t;

  typedef struct packed {
    logic pair_done;
    logic need_div;
    logic div_busy;
    logic quot_zero;
    logic out_free;
  } fsk_stat_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fsk_div.sv
// ----------------------------------------------------------------------------
// fsk_div
// Restoring divider, one quotient bit per cycle, for the bit repeat count.
// ----------------------------------------------------------------------------
`default_nettype none

module fsk_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [fsk_pkg::DIV_W-1:0]  dividend,
  input  wire logic [fsk_pkg::PPB_W-1:0]  divisor,
  output logic                            busy,
  output logic      [fsk_pkg::DIV_W-1:0]  quotient
);
  import fsk_pkg::*;

  logic [STEP_W-1:0] steps;
  logic [DIV_W-1:0]  quo;
  logic [PPB_W-1:0]  rem;
  logic [PPB_W-1:0]  dsr;
  logic [PPB_W:0]    rem_sh;
  logic              fits;

  assign rem_sh = {rem, quo[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= STEP_W'(DIV_W);
    end else if (steps != '0) begin
      steps <= steps - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (steps != '0) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? PPB_W'(rem_sh - {1'b0, dsr}) : rem_sh[PPB_W-1:0];
    end
  end

  assign busy     = steps != '0;
  assign quotient = quo;

endmodule

`default_nettype wire

FILE: rtl/fsk_dp.sv
// ----------------------------------------------------------------------------
// fsk_dp
// Datapath: configuration registers, run and pulse state, divider and the
// output holding register.
// ----------------------------------------------------------------------------
`default_nettype none

module fsk_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire fsk_pkg::fsk_cmd_t             cmd,
  output fsk_pkg::fsk_stat_t                 stat,
  input  wire logic                          in_level,
  input  wire logic                          in_first,
  input  wire logic                          cfg_we,
  input  wire logic [fsk_pkg::IDX_W-1:0]     cfg_idx,
  input  wire logic [fsk_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_value,
  output logic      [fsk_pkg::BCNT_W-1:0]    out_count
);
  import fsk_pkg::*;

  logic [CFG_W-1:0] min_period;
  logic [CFG_W-1:0] max_period;
  logic [CFG_W-1:0] split_period;
  logic [PPB_W-1:0] ppz;
  logic [PPB_W-1:0] ppo;

  logic             lat_level;
  logic             lat_first;

  logic             level_now;
  logic [CNT_W-1:0] run_length;
  logic [CNT_W-1:0] half_run_length;
  logic             half_seen;
  logic             pulse_known;
  logic             pulse_class;
  logic [CNT_W-1:0] tone_count;
  logic [PER_W-1:0] period;
  logic             emit_value;

  logic [CNT_W-1:0] rl_inc;
  logic [CMP_W-1:0] period_ext;
  logic             in_range;
  logic             pulse;
  logic [CNT_W-1:0] tc_inc;
  logic             change;
  logic [PPB_W-1:0] per_bit;
  logic [DIV_W-1:0] dividend;
  logic             div_start;
  logic             div_busy;
  logic [DIV_W-1:0] quotient;
  logic [QEXT_W-1:0] q_ext;
  logic [BCNT_W-1:0] q_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_period   <= MIN_PERIOD_RST;
      max_period   <= MAX_PERIOD_RST;
      split_period <= SPLIT_PERIOD_RST;
      ppz          <= PPZ_RST;
      ppo          <= PPO_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MIN_PERIOD:   min_period   <= cfg_wdata;
        REG_MAX_PERIOD:   max_period   <= cfg_wdata;
        REG_SPLIT_PERIOD: split_period <= cfg_wdata;
        REG_PPZ:          ppz          <= cfg_wdata[PPB_W-1:0];
        REG_PPO:          ppo          <= cfg_wdata[PPB_W-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lat_level <= in_level;
      lat_first <= in_first;
    end
  end

  assign rl_inc     = sat_inc(run_length);
  assign period_ext = CMP_W'(period);
  assign in_range   = (period_ext >= CMP_W'(min_period)) && (period_ext < CMP_W'(max_period));
  assign pulse      = period_ext >= CMP_W'(split_period);
  assign tc_inc     = sat_inc(tone_count);
  assign change     = pulse_known && (pulse != pulse_class);
  assign per_bit    = pulse_class ? ((ppo == '0) ? PPB_W'(1) : ppo)
                                  : ((ppz == '0) ? PPB_W'(1) : ppz);
  assign dividend   = DIV_W'(tc_inc) + DIV_W'(1);
  assign div_start  = cmd.classify && in_range && change;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_now       <= 1'b0;
      run_length      <= '0;
      half_run_length <= '0;
      half_seen       <= 1'b0;
      pulse_known     <= 1'b0;
      pulse_class     <= 1'b0;
      tone_count      <= '0;
    end else if (cmd.run) begin
      if (lat_first) begin
        level_now       <= lat_level;
        run_length      <= '0;
        half_run_length <= '0;
        half_seen       <= 1'b0;
        pulse_known     <= 1'b0;
        pulse_class     <= 1'b0;
        tone_count      <= '0;
      end else if (lat_level == level_now) begin
        run_length <= rl_inc;
      end else begin
        level_now  <= lat_level;
        run_length <= '0;
        half_seen  <= !half_seen;
        if (!half_seen) begin
          half_run_length <= rl_inc;
        end
      end
    end else if (cmd.classify) begin
      if (!in_range) begin
        tone_count <= '0;
      end else begin
        tone_count  <= change ? '0 : tc_inc;
        pulse_class <= pulse;
        pulse_known <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run) begin
      period <= PER_W'(half_run_length) + PER_W'(rl_inc);
    end
    if (div_start) begin
      emit_value <= pulse_class;
    end
  end

  fsk_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (per_bit),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign q_ext = QEXT_W'(quotient);
  assign q_sat = (q_ext > QEXT_W'(BCNT_MAX)) ? BCNT_MAX : q_ext[BCNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_value <= emit_value;
      out_count <= q_sat;
    end
  end

  assign stat.pair_done = !lat_first && (lat_level != level_now) && half_seen;
  assign stat.need_div  = in_range && change;
  assign stat.div_busy  = div_busy;
  assign stat.quot_zero = quotient == '0;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

FILE: rtl/fsk_ctrl.sv
// ----------------------------------------------------------------------------
// fsk_ctrl
// Controller: sequences latch, run update, classification, division and
// result hand-off for one sample.
// ----------------------------------------------------------------------------
`default_nettype none

module fsk_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire fsk_pkg::fsk_stat_t  stat,
  output fsk_pkg::fsk_cmd_t        cmd
);
  import fsk_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RUN   = 5'b00010,
    ST_CLASS = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_PUSH  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = ST_RUN;
      end
      ST_RUN: begin
        cmd.run    = 1'b1;
        state_next = stat.pair_done ? ST_CLASS : ST_IDLE;
      end
      ST_CLASS: begin
        cmd.classify = 1'b1;
        state_next   = stat.need_div ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (!stat.div_busy) state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (stat.quot_zero) begin
          state_next = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_ready = state == ST_IDLE;

endmodule

`default_nettype wire

FILE: rtl/fsk_run_pair_demodulator_unit.sv
// ----------------------------------------------------------------------------
// fsk_run_pair_demodulator_unit
// Run-pair FSK demodulator: pairs level runs into carrier periods, classes
// them and emits bit values with repeat counts.
// Each sample is latched in IDLE and applied in RUN; a closing run pair adds
// CLASS, and a class change adds DIV (one quotient bit per cycle) and PUSH.
// One request at a time; the next is taken once the last is done.
// Results wait in an output register while the next sample is taken.
// Reset: synchronous; restores register defaults and clears the run, pulse and tone state.
// ----------------------------------------------------------------------------
`default_nettype none

module fsk_run_pair_demodulator_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [fsk_pkg::IN_DATA_W-1:0]        s_tdata,   // [0] level, rest zero
  input  wire logic                                 s_tuser,   // [0] first_sample
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic      [fsk_pkg::OUT_DATA_W-1:0]       m_tdata,   // [0] bit_value, [16:1] bit_count
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [fsk_pkg::IDX_W-1:0]            cfg_index,
  input  wire logic [fsk_pkg::CFG_W-1:0]            cfg_data
);
  import fsk_pkg::*;

  fsk_cmd_t          cmd;
  fsk_stat_t         stat;
  logic              out_value;
  logic [BCNT_W-1:0] out_count;

  assign cfg_ready = 1'b1;

  fsk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fsk_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_level  (s_tdata[0]),
    .in_first  (s_tuser),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (out_value),
    .out_count (out_count)
  );

  assign m_tdata = OUT_DATA_W'({out_count, out_value});

endmodule

`default_nettype wire
